// ===== design/bhlf_pkg.sv =====
// Shared types and constants for the binomial halving line filter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package bhlf_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int VALUE_BITS    = SAMPLE_BITS + 4;
  localparam int SRC_LEN_BITS  = 13;
  localparam int MIN_LEN       = 6;
  localparam int MAX_LEN       = 4096;
  localparam int COUNT_BITS    = $clog2(MAX_LEN);
  localparam int SRC_LEN_RESET = 640;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = SRC_LEN_BITS;

  // Output queue: up to two words enter per cycle, one leaves.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;
  localparam int MAX_PUSH      = 2;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [VALUE_BITS-1:0]    value_t;
  typedef logic [FIFO_CNT_BITS-1:0] fifo_cnt_t;
  typedef logic [1:0]               push_cnt_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SRC_LEN  = 4'd0,
    REG_ROUND_UP = 4'd1
  } reg_idx_e;

  // Tap set of the first word produced by a sample.
  typedef enum logic [1:0] {
    ROW_EDGE_HEAD,
    ROW_FULL,
    ROW_SHORT,
    ROW_EDGE_TAIL
  } row_kind_e;

  typedef struct packed {
    sample_t   cur;
    sample_t   w0;
    sample_t   w1;
    sample_t   w2;
    sample_t   w3;
    row_kind_e kind;
    push_cnt_t n_res;
  } stage_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } result_t;

endpackage

// ===== design/bhlf_if.sv =====
// Handshake channel interfaces: sample input, result output, config writes.
// Depends on bhlf_pkg.
`timescale 1ns / 1ps

interface bhlf_sample_if;
  import bhlf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bhlf_result_if;
  import bhlf_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bhlf_cfg_if;
  import bhlf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bhlf_front.sv =====
// Front end: config registers, sample counter, 4-deep sample window, row
// decode and the input stage register. Depends on bhlf_pkg and bhlf_if.
`timescale 1ns / 1ps

module bhlf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bhlf_cfg_if.sink             cfg_i,
  bhlf_sample_if.sink          sample_i,
  input  bhlf_pkg::fifo_cnt_t  fifo_cnt_i,
  output logic                 stage_valid_o,
  output bhlf_pkg::stage_t     stage_o
);
  import bhlf_pkg::*;

  localparam logic [SRC_LEN_BITS-1:0] LenMin   = SRC_LEN_BITS'(MIN_LEN);
  localparam logic [SRC_LEN_BITS-1:0] LenMax   = SRC_LEN_BITS'(MAX_LEN);
  localparam logic [FIFO_CNT_BITS:0]  OccLimit = (FIFO_CNT_BITS+1)'(FIFO_DEPTH - MAX_PUSH);

  logic [SRC_LEN_BITS-1:0] src_len_q;
  logic                    round_up_q;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  sample_t                 w0_q, w1_q, w2_q, w3_q;
  logic                    stage_valid_q;
  stage_t                  stage_q, stage_d;

  logic [SRC_LEN_BITS-1:0] s_len, d2, i_ext, i_inc;
  logic                    full, accept;
  logic                    is_head, is_mid, is_short, is_tail;
  logic [FIFO_CNT_BITS:0]  occ;

  assign cfg_i.ready = 1'b1;

  // Words already queued plus words still in the stage, plus room for two more.
  assign occ = {1'b0, fifo_cnt_i}
             + (FIFO_CNT_BITS+1)'(stage_valid_q ? stage_q.n_res : 2'd0);
  assign sample_i.ready = (occ <= OccLimit);
  assign accept = sample_i.valid && sample_i.ready;

  always_comb begin
    if (src_len_q < LenMin) begin
      s_len = LenMin;
    end else if (src_len_q > LenMax) begin
      s_len = LenMax;
    end else begin
      s_len = src_len_q;
    end
    // d2 is twice the output length
    d2    = round_up_q ? ((s_len + 1'b1) & ~SRC_LEN_BITS'(1)) : (s_len & ~SRC_LEN_BITS'(1));
    full  = !(round_up_q && s_len[0]);
    i_ext = SRC_LEN_BITS'(cnt_q);
    i_inc = i_ext + 1'b1;

    is_head  = (i_ext == SRC_LEN_BITS'(2));
    is_mid   = (i_ext >= SRC_LEN_BITS'(4)) && !i_ext[0] && (i_ext + SRC_LEN_BITS'(4) <= d2);
    is_short = !full && (i_ext + SRC_LEN_BITS'(3) == d2);
    is_tail  = (i_ext + SRC_LEN_BITS'(2) == d2);

    stage_d.cur  = sample_i.sample;
    stage_d.w0   = w0_q;
    stage_d.w1   = w1_q;
    stage_d.w2   = w2_q;
    stage_d.w3   = w3_q;
    stage_d.kind = ROW_FULL;
    stage_d.n_res = 2'd0;
    if (is_head) begin
      stage_d.kind  = ROW_EDGE_HEAD;
      stage_d.n_res = 2'd1;
    end else if (is_mid) begin
      stage_d.n_res = 2'd1;
    end else if (is_short) begin
      stage_d.kind  = ROW_SHORT;
      stage_d.n_res = 2'd1;
    end else if (is_tail) begin
      // full length: last five-tap row and the tail row leave together
      stage_d.kind  = full ? ROW_FULL : ROW_EDGE_TAIL;
      stage_d.n_res = full ? 2'd2 : 2'd1;
    end

    cnt_d = (i_inc >= s_len) ? '0 : i_inc[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q     <= SRC_LEN_BITS'(SRC_LEN_RESET);
      round_up_q    <= 1'b0;
      cnt_q         <= '0;
      w0_q          <= '0;
      w1_q          <= '0;
      w2_q          <= '0;
      w3_q          <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_SRC_LEN:  src_len_q  <= cfg_i.data;
          REG_ROUND_UP: round_up_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      stage_valid_q <= accept;
      if (accept) begin
        cnt_q <= cnt_d;
        w3_q  <= w2_q;
        w2_q  <= w1_q;
        w1_q  <= w0_q;
        w0_q  <= sample_i.sample;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

// ===== design/bhlf_taps.sv =====
// Shift-add tap sums for the staged sample and window.
// Depends on bhlf_pkg.
`timescale 1ns / 1ps

module bhlf_taps (
  input  logic                 stage_valid_i,
  input  bhlf_pkg::stage_t     stage_i,
  output bhlf_pkg::push_cnt_t  push_cnt_o,
  output bhlf_pkg::result_t    push0_o,
  output bhlf_pkg::result_t    push1_o
);
  import bhlf_pkg::*;

  function automatic value_t tap_sum(row_kind_e kind, stage_t st);
    value_t c, a, b, d, e, s;
    c = value_t'(st.cur);
    a = value_t'(st.w0);
    b = value_t'(st.w1);
    d = value_t'(st.w2);
    e = value_t'(st.w3);
    case (kind)
      ROW_EDGE_HEAD: s = (b << 3) + (b << 1) + b + (a << 2) + c;
      ROW_FULL:      s = e + (d << 2) + (b << 2) + (b << 1) + (a << 2) + c;
      ROW_SHORT:     s = d + (b << 2) + (a << 2) + (a << 1) + (c << 2) + c;
      default:       s = b + (a << 2) + (c << 3) + (c << 1) + c;
    endcase
    return s;
  endfunction

  assign push_cnt_o    = stage_valid_i ? stage_i.n_res : 2'd0;
  assign push0_o.value = tap_sum(stage_i.kind, stage_i);
  assign push0_o.last  = (stage_i.kind == ROW_EDGE_TAIL);
  // second word, when present, is always the tail row
  assign push1_o.value = tap_sum(ROW_EDGE_TAIL, stage_i);
  assign push1_o.last  = 1'b1;

endmodule

// ===== design/bhlf_out_fifo.sv =====
// Four-word output queue, two write ports, one read port driving the
// result channel. Depends on bhlf_pkg and bhlf_if.
`timescale 1ns / 1ps

module bhlf_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bhlf_pkg::push_cnt_t  push_cnt_i,
  input  bhlf_pkg::result_t    push0_i,
  input  bhlf_pkg::result_t    push1_i,
  output bhlf_pkg::fifo_cnt_t  cnt_o,
  bhlf_result_if.source        result_o
);
  import bhlf_pkg::*;

  result_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  fifo_cnt_t                cnt_q, cnt_d;
  logic                     pop;

  assign pop       = result_o.valid && result_o.ready;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign cnt_d     = cnt_q + FIFO_CNT_BITS'(push_cnt_i) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign result_o.valid = (cnt_q != '0);
  assign result_o.value = mem[rd_ptr_q].value;
  assign result_o.last  = mem[rd_ptr_q].last;
  assign cnt_o          = cnt_q;

endmodule

// ===== design/binomial_halving_line_filter.sv =====
// Binomial halving line filter: 1-4-6-4-1 reduce of one line to half length.
// Top level; depends on bhlf_pkg, bhlf_if, bhlf_front, bhlf_taps, bhlf_out_fifo.
`timescale 1ns / 1ps

// Takes one sample per clock on sample_i and returns 16x the filtered value on
// result_o, one word per output row, with last set on the final row of a line.
// A sample produces zero, one or two words; each word passes through the input stage
// register and then the output queue before it appears on result_o. The
// output queue is four words deep and accepts two words per cycle; sample_i.ready
// drops only while queued and in-flight words leave less than two free slots,
// so with result_o.ready held high the block takes a sample every cycle.
// Config writes on cfg_i are always taken and belong between lines.
module binomial_halving_line_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  bhlf_cfg_if.sink      cfg_i,
  bhlf_sample_if.sink   sample_i,
  bhlf_result_if.source result_o
);
  import bhlf_pkg::*;

  logic      stage_valid;
  stage_t    stage;
  push_cnt_t push_cnt;
  result_t   push0, push1;
  fifo_cnt_t fifo_cnt;

  bhlf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .sample_i      (sample_i),
    .fifo_cnt_i    (fifo_cnt),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  bhlf_taps u_taps (
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .push_cnt_o    (push_cnt),
    .push0_o       (push0),
    .push1_o       (push1)
  );

  bhlf_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (push1),
    .cnt_o      (fifo_cnt),
    .result_o   (result_o)
  );

endmodule

// ===== design/bhlf_checker.sv =====
// Port-level checks for the binomial halving line filter, bound to the top.
// Depends on bhlf_pkg and binomial_halving_line_filter.
`timescale 1ns / 1ps

module bhlf_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [bhlf_pkg::VALUE_BITS-1:0] out_value_i,
  input logic                     out_last_i
);
  import bhlf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
                                    && $stable(out_last_i))
    else $error("result word changed while stalled");

  // input backpressure only while words are waiting
  a_bp_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output queue");

  // a word shows up only as the result of an accepted sample
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result word without a matching sample");

endmodule

bind binomial_halving_line_filter bhlf_checker u_bhlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_value_i (result_o.value),
  .out_last_i  (result_o.last)
);

// ===== dv/tb_binomial_halving_line_filter.sv =====
// Self-checking testbench for binomial_halving_line_filter: directed lines, then random
// lines over many length and rounding settings, checked against an in-bench row predictor.
// Depends on bhlf_pkg, the bhlf_if interfaces and the design files.
`timescale 1ns / 1ps

module tb_binomial_halving_line_filter;
  import bhlf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SETTLE       = 4;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          BIG_PHASE    = 6;
  localparam int          HOLD_PHASE   = 2;

  localparam logic [CFG_IDX_BITS-1:0]  REG_IDX_SPARE = '1;
  localparam logic [CFG_DATA_BITS-1:0] LEN_ALL_ONES  = '1;
  localparam sample_t                  SAMPLE_MAX    = '1;
  localparam value_t FULL_ROW = value_t'(16 * ((1 << SAMPLE_BITS) - 1));

  typedef enum logic {STEP_CFG, STEP_SAMPLE} step_kind_e;

  typedef struct {
    step_kind_e              kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [SAMPLE_BITS-1:0]  data;
    int                      n_typed;  // -1: rows come from the predictor
    result_t                 r0;
    result_t                 r1;
  } step_t;

  logic clk_i;
  logic rst_ni;

  bhlf_cfg_if    cfg ();
  bhlf_sample_if smp ();
  bhlf_result_if rsp ();

  binomial_halving_line_filter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (smp),
    .result_o (rsp)
  );

  // predictor state
  logic [SRC_LEN_BITS-1:0] len_reg;
  logic                    round_reg;
  sample_t                 win [4];
  int unsigned             line_pos;

  result_t step_rows [$];
  result_t rows_owed [$];
  step_t   plan [$];

  int fault_cnt;
  int rsp_wait;
  bit snd_burst;
  bit rsp_burst;
  bit hold_go;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SAMPLE_MAX;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned eff_len(input logic [SRC_LEN_BITS-1:0] len);
    if (len < MIN_LEN) return MIN_LEN;
    if (len > MAX_LEN) return MAX_LEN;
    return len;
  endfunction

  function automatic void add_row(input int unsigned v, input logic l);
    result_t r;
    r.value = value_t'(v);
    r.last  = l;
    step_rows.push_back(r);
  endfunction

  // Rows caused by one sample; updates the window and line position.
  function automatic void reduce_sample(input sample_t cur);
    int unsigned s_len, d_len, i, c, w0, w1, w2, w3, five;
    bit          full;
    step_rows.delete();
    s_len = eff_len(len_reg);
    d_len = round_reg ? (s_len + 1) / 2 : s_len / 2;
    full  = (2 * d_len <= s_len);
    i  = line_pos;
    c  = cur;
    w0 = win[0];
    w1 = win[1];
    w2 = win[2];
    w3 = win[3];
    five = w3 + 4 * w2 + 6 * w1 + 4 * w0 + c;
    if (i == 2) begin
      add_row(11 * w1 + 4 * w0 + c, 1'b0);
    end else if (i >= 4 && i % 2 == 0 && i <= 2 * d_len - 4) begin
      add_row(five, 1'b0);
    end
    // short tail form when the line is one sample short of 2D
    if (!full && i == 2 * d_len - 3) begin
      add_row(w2 + 4 * w1 + 6 * w0 + 5 * c, 1'b0);
    end
    if (i == 2 * d_len - 2) begin
      if (full) add_row(five, 1'b0);
      add_row(w1 + 4 * w0 + 11 * c, 1'b1);
    end
    win[3] = win[2];
    win[2] = win[1];
    win[1] = win[0];
    win[0] = cur;
    line_pos = (i + 1 >= s_len) ? 0 : i + 1;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
    step_t st;
    st.kind    = STEP_CFG;
    st.idx     = idx;
    st.data    = SAMPLE_BITS'(data);
    st.n_typed = -1;
    st.r0      = '0;
    st.r1      = '0;
    plan.push_back(st);
  endfunction

  function automatic void add_typed(input sample_t s, input int n,
                                    input value_t v0, input logic l0,
                                    input value_t v1, input logic l1);
    step_t st;
    st.kind     = STEP_SAMPLE;
    st.idx      = REG_SRC_LEN;
    st.data     = s;
    st.n_typed  = n;
    st.r0.value = v0;
    st.r0.last  = l0;
    st.r1.value = v1;
    st.r1.last  = l1;
    plan.push_back(st);
  endfunction

  // Called at a falling edge; returns at the falling edge after the handshake.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    if (idx == REG_SRC_LEN) len_reg = data;
    else if (idx == REG_ROUND_UP) round_reg = data[0];
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic send_step(input step_t st);
    int gap;
    gap = draw_wait(snd_burst);
    if (gap > 0) begin
      smp.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp.valid  = 1'b1;
    smp.sample = st.data;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    reduce_sample(st.data);
    if (st.n_typed < 0) begin
      foreach (step_rows[k]) rows_owed.push_back(step_rows[k]);
    end else begin
      if (st.n_typed > 0) rows_owed.push_back(st.r0);
      if (st.n_typed > 1) rows_owed.push_back(st.r1);
    end
    @(negedge clk_i);
  endtask

  // Block is idle once every owed row is out and the pipe has settled.
  task automatic wait_idle();
    smp.valid = 1'b0;
    while (rows_owed.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // receiver: random stall per word, plus one long hold-off
  initial begin
    rsp.ready = 1'b0;
    rsp_wait  = 0;
    forever begin
      @(negedge clk_i);
      rsp.ready = rst_ni && !hold_off && rsp_wait == 0;
      if (rsp_wait > 0) rsp_wait--;
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (rows_owed.size() == 0) begin
        fault_cnt++;
        $display("%0t: unexpected word: expected none, got value %h last %b",
                 $time, rsp.value, rsp.last);
      end else begin
        want = rows_owed.pop_front();
        if (rsp.value !== want.value) begin
          fault_cnt++;
          $display("%0t: value mismatch: expected %h, got %h",
                   $time, want.value, rsp.value);
        end
        if (rsp.last !== want.last) begin
          fault_cnt++;
          $display("%0t: last mismatch: expected %b, got %b",
                   $time, want.last, rsp.last);
        end
      end
      rsp_wait = draw_wait(rsp_burst);
    end
  end

  initial begin
    step_t       st;
    int          phase;
    int          small_items;
    int          lines;
    int          total;
    int unsigned s_eff;
    logic [CFG_DATA_BITS-1:0] len;

    rst_ni     = 1'b0;
    cfg.valid  = 1'b0;
    cfg.index  = REG_SRC_LEN;
    cfg.data   = '0;
    smp.valid  = 1'b0;
    smp.sample = '0;
    fault_cnt  = 0;
    snd_burst  = 1'b0;
    rsp_burst  = 1'b0;
    hold_go    = 1'b0;
    len_reg    = SRC_LEN_BITS'(SRC_LEN_RESET);
    round_reg  = 1'b0;
    line_pos   = 0;
    foreach (win[k]) win[k] = '0;

    // shortest line, floor rounding: D = 3, rows at samples 2 and 4
    add_cfg(REG_SRC_LEN, '0);
    add_cfg(REG_ROUND_UP, '0);
    add_typed(SAMPLE_MAX, 0, '0, 1'b0, '0, 1'b0);
    add_typed(SAMPLE_MAX, 0, '0, 1'b0, '0, 1'b0);
    add_typed(SAMPLE_MAX, 1, FULL_ROW, 1'b0, '0, 1'b0);
    add_typed(SAMPLE_MAX, 0, '0, 1'b0, '0, 1'b0);
    add_typed(SAMPLE_MAX, 2, FULL_ROW, 1'b0, FULL_ROW, 1'b1);
    add_typed(SAMPLE_MAX, 0, '0, 1'b0, '0, 1'b0);
    add_typed('0, 0, '0, 1'b0, '0, 1'b0);
    add_typed('0, 0, '0, 1'b0, '0, 1'b0);
    add_typed('0, 1, '0, 1'b0, '0, 1'b0);
    add_typed('0, 0, '0, 1'b0, '0, 1'b0);
    add_typed('0, 2, '0, 1'b0, '0, 1'b1);
    add_typed('0, 0, '0, 1'b0, '0, 1'b0);
    // odd length rounded up: short 1,4,6,5 row before the last
    add_cfg(REG_SRC_LEN, CFG_DATA_BITS'(7));
    add_cfg(REG_ROUND_UP, CFG_DATA_BITS'(1));
    add_typed(16'h5555, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'hAAAA, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h0001, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h8000, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h7FFF, -1, '0, 1'b0, '0, 1'b0);
    add_typed(SAMPLE_MAX, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h0003, -1, '0, 1'b0, '0, 1'b0);
    // partial line, then shrink the length so the position is already at the end
    add_typed(16'h1234, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'hFEDC, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h0F0F, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'hF0F0, -1, '0, 1'b0, '0, 1'b0);
    add_typed(16'h00FF, -1, '0, 1'b0, '0, 1'b0);
    add_cfg(REG_SRC_LEN, CFG_DATA_BITS'(4));
    add_typed(16'hFF00, 0, '0, 1'b0, '0, 1'b0);
    add_cfg(REG_IDX_SPARE, LEN_ALL_ONES);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CFG) begin
        wait_idle();
        write_reg(plan[k].idx, plan[k].data[CFG_DATA_BITS-1:0]);
      end else begin
        send_step(plan[k]);
      end
    end

    st.kind    = STEP_SAMPLE;
    st.idx     = REG_SRC_LEN;
    st.n_typed = -1;
    st.r0      = '0;
    st.r1      = '0;
    phase       = 0;
    small_items = 0;
    while (small_items < RANDOM_ITEMS || phase <= BIG_PHASE) begin
      wait_idle();
      snd_burst = ($urandom_range(0, 4) == 0);
      rsp_burst = ($urandom_range(0, 4) == 0);
      if (phase == HOLD_PHASE) begin
        // sender runs flat out while the receiver holds off
        snd_burst = 1'b1;
        hold_go   = 1'b1;
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(REG_ROUND_UP + 1, (1 << CFG_IDX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
      if (phase == BIG_PHASE) begin
        len = LEN_ALL_ONES;
      end else begin
        case ($urandom_range(0, 9))
          0:       len = CFG_DATA_BITS'($urandom_range(0, MIN_LEN - 1));
          1, 2:    len = CFG_DATA_BITS'($urandom_range(25, 200));
          default: len = CFG_DATA_BITS'($urandom_range(MIN_LEN, 24));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SRC_LEN, len);
        write_reg(REG_ROUND_UP, CFG_DATA_BITS'($urandom));
      end else begin
        write_reg(REG_ROUND_UP, CFG_DATA_BITS'($urandom));
        write_reg(REG_SRC_LEN, len);
      end
      s_eff = eff_len(len);
      lines = (phase == BIG_PHASE) ? 1 : $urandom_range(1, 3);
      total = lines * s_eff;
      // leave a partial line now and then so the next write lands mid-line
      if (phase != BIG_PHASE && $urandom_range(0, 3) == 0)
        total += $urandom_range(1, s_eff - 1);
      repeat (total) begin
        st.data = draw_sample();
        send_step(st);
      end
      if (phase != BIG_PHASE) small_items += total;
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fault_cnt == 0 && rows_owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
